>>> src/kmeans_color_quantizer_defines.svh
// Assertion macros shared by the quantizer RTL.
// Depends on nothing; included by the top level only.
`ifndef KMEANS_COLOR_QUANTIZER_DEFINES_SVH
`define KMEANS_COLOR_QUANTIZER_DEFINES_SVH

// Condition a implies condition b in the same cycle.
`define KMQ_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("kmq assertion failed");

// Condition a implies condition b in the next cycle.
`define KMQ_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("kmq assertion failed");

`endif

>>> src/kmq_pkg.sv
// Shared types and constants of the k-means color quantizer.
// Depends on nothing; imported by every module of the block.
package kmq_pkg;

  localparam int MAX_PIXELS   = 262144;
  localparam int MAX_COLORS   = 16;
  localparam int PIX_AW       = $clog2(MAX_PIXELS);
  localparam int CNT_W        = PIX_AW + 1;
  localparam int LBL_W        = 4;
  localparam int ENTRY_W      = LBL_W + 24;
  localparam int SUM_W        = CNT_W + 8;
  localparam int DIST_W       = 18;
  localparam int DRAIN_W      = 6;
  localparam logic [DRAIN_W-1:0] DRAIN_CYCLES = 6'd36;

  localparam logic [4:0] NUM_COLORS_RESET = 5'd16;
  localparam logic [7:0] MAX_PASSES_RESET = 8'd24;

  localparam logic [1:0] CFG_NUM_COLORS    = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_ORDER = 2'd1;
  localparam logic [1:0] CFG_MAX_PASSES    = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [31:0] pixel_word;
    logic [3:0]  initial_label;
    logic        last_pixel;
    logic [16:0] byte_index;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] palette_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] packed_byte;
    logic [7:0] passes_used;
    logic       last;
  } out_word_t;

  // Pixel moving down the row of cells during reassignment.
  typedef struct packed {
    logic              valid;
    logic [PIX_AW-1:0] idx;
    logic [23:0]       rgb;
    logic [LBL_W-1:0]  old_label;
    logic [LBL_W-1:0]  best;
    logic [DIST_W-1:0] bestd;
  } chain_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic             clear;
    logic             acc_en;
    logic [LBL_W-1:0] acc_label;
    logic [23:0]      acc_rgb;
    logic             cen_we;
    logic [LBL_W-1:0] cen_cell;
    logic [1:0]       cen_chan;
    logic [7:0]       cen_val;
    logic [4:0]       nc;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_A, ST_RD_B, ST_RD_C, ST_RESP, ST_CLAMP, ST_CLEAR,
    ST_ACC, ST_DIV, ST_ASSIGN, ST_DRAIN, ST_CHECK, ST_EMIT
  } state_t;

endpackage

>>> src/kmq_ram.sv
// Pixel store: one write port and one registered read port.
// Depends on kmq_pkg.
module kmq_ram import kmq_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [PIX_AW-1:0]  waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic [PIX_AW-1:0]  raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [MAX_PIXELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/kmq_cell.sv
// One cluster cell: centroid, running sums, and a two-stage distance compare.
// Depends on kmq_pkg.
module kmq_cell import kmq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [LBL_W-1:0]  cell_id,
  input  cell_ctrl_t        ctrl,
  input  chain_t            chain_in,
  output chain_t            chain_out,
  output logic [SUM_W-1:0]  sum_r,
  output logic [SUM_W-1:0]  sum_g,
  output logic [SUM_W-1:0]  sum_b,
  output logic [CNT_W-1:0]  size,
  output logic [23:0]       centroid
);

  chain_t              a_q;
  chain_t              chain_next;
  logic [DIST_W-1:0]   a_dist;
  logic signed [8:0]   dr, dg, db;
  logic signed [17:0]  sqr, sqg, sqb;
  logic [DIST_W-1:0]   sq_dist;
  logic                en;
  logic                take;

  assign dr  = $signed({1'b0, centroid[23:16]}) - $signed({1'b0, chain_in.rgb[23:16]});
  assign dg  = $signed({1'b0, centroid[15:8]}) - $signed({1'b0, chain_in.rgb[15:8]});
  assign db  = $signed({1'b0, centroid[7:0]}) - $signed({1'b0, chain_in.rgb[7:0]});
  assign sqr = dr * dr;
  assign sqg = dg * dg;
  assign sqb = db * db;
  assign sq_dist = DIST_W'($unsigned(sqr)) + DIST_W'($unsigned(sqg)) + DIST_W'($unsigned(sqb));

  assign en   = {1'b0, cell_id} < ctrl.nc;
  assign take = en && ((cell_id == '0) || (a_dist < a_q.bestd));

  always_comb begin
    chain_next = a_q;
    if (take) begin
      chain_next.best  = cell_id;
      chain_next.bestd = a_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_q       <= '0;
      chain_out <= '0;
    end else begin
      a_q       <= chain_in;
      a_dist    <= sq_dist;
      chain_out <= chain_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
      size  <= '0;
    end else if (ctrl.acc_en && ctrl.acc_label == cell_id) begin
      sum_r <= sum_r + SUM_W'(ctrl.acc_rgb[23:16]);
      sum_g <= sum_g + SUM_W'(ctrl.acc_rgb[15:8]);
      sum_b <= sum_b + SUM_W'(ctrl.acc_rgb[7:0]);
      size  <= size + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      centroid <= '0;
    end else if (ctrl.cen_we && ctrl.cen_cell == cell_id) begin
      case (ctrl.cen_chan)
        CHAN_RED:   centroid[23:16] <= ctrl.cen_val;
        CHAN_GREEN: centroid[15:8]  <= ctrl.cen_val;
        default:    centroid[7:0]   <= ctrl.cen_val;
      endcase
    end
  end

endmodule

>>> src/kmq_divider.sv
// Restoring divider for cluster means, one quotient bit per cycle.
// Depends on kmq_pkg; the quotient always fits in eight bits.
module kmq_divider import kmq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [7:0]       quotient
);

  logic             busy;
  logic [2:0]       cnt;
  logic [SUM_W-1:0] rem;
  logic [CNT_W-1:0] dvs;
  logic [7:0]       q;
  logic [SUM_W-1:0] shifted;

  assign shifted  = SUM_W'(dvs) << cnt;
  assign quotient = (dvs == '0) ? 8'd0 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd7;
        rem  <= dividend;
        dvs  <= divisor;
        q    <= '0;
      end else if (busy) begin
        if (rem >= shifted) begin
          rem    <= rem - shifted;
          q[cnt] <= 1'b1;
        end
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

>>> src/kmeans_color_quantizer.sv
// K-means color quantizer: loads are taken in ST_IDLE; a byte read steps through ST_RD_A,
// ST_RD_B, ST_RD_C and ST_RESP before its word is registered. A load with last_pixel
// runs its passes over the stored pixels (one store read port), then emits the palette.
// The reassignment sweep streams one pixel per cycle through a row of 16 cells.
// Reset is synchronous and active high: state, counts, flags and settings take defaults;
// the pixel store keeps whatever it held and is only read where written.
`include "kmeans_color_quantizer_defines.svh"
module kmeans_color_quantizer import kmq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // Configuration registers.
  logic [4:0] num_colors;
  logic       channel_order;
  logic [7:0] max_passes;
  logic [4:0] nc;
  logic [3:0] ncm1;
  logic [7:0] maxp;

  state_t state, state_next, drain_ret;

  logic [CNT_W-1:0]   pixel_count;
  logic               frame_done;
  logic [CNT_W-1:0]   sweep_addr;
  logic [DRAIN_W-1:0] drain_cnt;
  logic [7:0]         passes;
  logic               changed;
  logic [3:0]         div_cell;
  logic [1:0]         div_chan;
  logic               div_wait;
  logic [3:0]         emit_idx;
  logic [PIX_AW-1:0]  rd_p;
  logic [3:0]         nib_hi, nib_lo;

  // Pipeline tags for words coming back from the pixel store.
  logic              rd_clamp_q, rd_acc_q, rd_asn_q;
  logic [PIX_AW-1:0] rd_addr_q;

  logic               accept;
  logic               is_sweep;
  logic               rd_issue;
  logic               sweep_done;
  logic               out_free;
  logic               out_load;
  out_word_t          out_next;
  logic [CNT_W-1:0]   load_base;

  logic               mem_we;
  logic [PIX_AW-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [PIX_AW-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_q;
  logic [LBL_W-1:0]   clamped;
  logic [7:0]         pr, pg, pb;

  logic               div_start;
  logic               div_done;
  logic [7:0]         div_q;
  logic [SUM_W-1:0]   div_dividend;
  logic               div_last;

  cell_ctrl_t         ctrl;
  chain_t             links [MAX_COLORS + 1];
  logic [SUM_W-1:0]   sum_r [MAX_COLORS];
  logic [SUM_W-1:0]   sum_g [MAX_COLORS];
  logic [SUM_W-1:0]   sum_b [MAX_COLORS];
  logic [CNT_W-1:0]   sizes [MAX_COLORS];
  logic [23:0]        cents [MAX_COLORS];

  // Out-of-range settings fold to the nearest legal value.
  assign nc   = (num_colors == '0) ? 5'd1 :
                (num_colors > 5'(MAX_COLORS)) ? 5'(MAX_COLORS) : num_colors;
  assign ncm1 = 4'(nc - 5'd1);
  assign maxp = (max_passes == '0) ? 8'd1 : max_passes;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign is_sweep   = (state == ST_CLAMP) || (state == ST_ACC) || (state == ST_ASSIGN);
  assign rd_issue   = is_sweep && (sweep_addr < pixel_count);
  assign sweep_done = is_sweep && !(sweep_addr < pixel_count);

  // A new frame restarts the count at the first load after a run.
  assign load_base = frame_done ? '0 : pixel_count;

  always_comb begin
    if (channel_order) begin
      pr = in_data.pixel_word[15:8];
      pg = in_data.pixel_word[23:16];
      pb = in_data.pixel_word[31:24];
    end else begin
      pr = in_data.pixel_word[31:24];
      pg = in_data.pixel_word[23:16];
      pb = in_data.pixel_word[15:8];
    end
  end

  assign clamped = ({1'b0, mem_q[27:24]} >= nc) ? ncm1 : mem_q[27:24];

  kmq_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // Row of cells: each holds one cluster and hands the pixel to the next.
  assign links[0] = '{valid: rd_asn_q, idx: rd_addr_q, rgb: mem_q[23:0],
                      old_label: mem_q[27:24], best: '0, bestd: '0};

  for (genvar g = 0; g < MAX_COLORS; g++) begin : g_cell
    kmq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_id   (LBL_W'(g)),
      .ctrl      (ctrl),
      .chain_in  (links[g]),
      .chain_out (links[g+1]),
      .sum_r     (sum_r[g]),
      .sum_g     (sum_g[g]),
      .sum_b     (sum_b[g]),
      .size      (sizes[g]),
      .centroid  (cents[g])
    );
  end

  always_comb begin
    case (div_chan)
      CHAN_RED:   div_dividend = sum_r[div_cell];
      CHAN_GREEN: div_dividend = sum_g[div_cell];
      default:    div_dividend = sum_b[div_cell];
    endcase
  end

  kmq_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (sizes[div_cell]),
    .done     (div_done),
    .quotient (div_q)
  );

  assign div_last = (div_cell == ncm1) && (div_chan == CHAN_BLUE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.opcode == OP_READ) begin
            state_next = ST_RD_A;
          end else if (in_data.last_pixel) begin
            state_next = ST_CLAMP;
          end
        end
      end
      ST_RD_A:  state_next = ST_RD_B;
      ST_RD_B:  state_next = ST_RD_C;
      ST_RD_C:  state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLAMP, ST_ACC, ST_ASSIGN: begin
        if (sweep_done) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == '0) begin
          state_next = drain_ret;
        end
      end
      ST_CLEAR: state_next = ST_ACC;
      ST_DIV: begin
        if (div_wait && div_done && div_last) begin
          state_next = ST_ASSIGN;
        end
      end
      ST_CHECK: begin
        if (changed && (passes + 8'd1) < maxp) begin
          state_next = ST_CLEAR;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && emit_idx == ncm1) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath strobes.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr_q;
    mem_wdata = {clamped, mem_q[23:0]};
    if (accept && in_data.opcode == OP_LOAD && load_base < CNT_W'(MAX_PIXELS)) begin
      mem_we    = 1'b1;
      mem_waddr = load_base[PIX_AW-1:0];
      mem_wdata = {in_data.initial_label, pr, pg, pb};
    end else if (rd_clamp_q) begin
      mem_we = 1'b1;
    end else if (links[MAX_COLORS].valid) begin
      mem_we    = 1'b1;
      mem_waddr = links[MAX_COLORS].idx;
      mem_wdata = {links[MAX_COLORS].best, links[MAX_COLORS].rgb};
    end

    case (state)
      ST_RD_A: mem_raddr = rd_p;
      ST_RD_B: mem_raddr = rd_p + 1'b1;
      default: mem_raddr = sweep_addr[PIX_AW-1:0];
    endcase

    div_start = (state == ST_DIV) && !div_wait;

    ctrl.clear     = (state == ST_CLEAR);
    ctrl.acc_en    = rd_acc_q;
    ctrl.acc_label = mem_q[27:24];
    ctrl.acc_rgb   = mem_q[23:0];
    ctrl.cen_we    = (state == ST_DIV) && div_wait && div_done;
    ctrl.cen_cell  = div_cell;
    ctrl.cen_chan  = div_chan;
    ctrl.cen_val   = div_q;
    ctrl.nc        = nc;

    out_load = out_free && ((state == ST_RESP) || (state == ST_EMIT));
    out_next = '0;
    out_next.passes_used = passes;
    if (state == ST_RESP) begin
      out_next.kind        = KIND_READ;
      out_next.packed_byte = {nib_hi, nib_lo};
      out_next.last        = 1'b1;
    end else begin
      out_next.kind          = KIND_PALETTE;
      out_next.palette_index = emit_idx;
      out_next.red           = cents[emit_idx][23:16];
      out_next.green         = cents[emit_idx][15:8];
      out_next.blue          = cents[emit_idx][7:0];
      out_next.last          = (emit_idx == ncm1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      drain_ret     <= ST_IDLE;
      num_colors    <= NUM_COLORS_RESET;
      channel_order <= 1'b0;
      max_passes    <= MAX_PASSES_RESET;
      pixel_count   <= '0;
      frame_done    <= 1'b0;
      sweep_addr    <= '0;
      drain_cnt     <= '0;
      passes        <= '0;
      changed       <= 1'b0;
      div_cell      <= '0;
      div_chan      <= CHAN_RED;
      div_wait      <= 1'b0;
      emit_idx      <= '0;
      rd_clamp_q    <= 1'b0;
      rd_acc_q      <= 1'b0;
      rd_asn_q      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NUM_COLORS:    num_colors    <= cfg_data[4:0];
          CFG_CHANNEL_ORDER: channel_order <= cfg_data[0];
          CFG_MAX_PASSES:    max_passes    <= cfg_data;
          default: ;
        endcase
      end

      // Loads; a load past the store size keeps the count but still starts a run.
      // The pass count of the previous run stays readable until the next run starts.
      if (accept && in_data.opcode == OP_LOAD) begin
        frame_done  <= 1'b0;
        pixel_count <= (load_base < CNT_W'(MAX_PIXELS)) ? load_base + 1'b1 : load_base;
        if (in_data.last_pixel) begin
          passes <= '0;
        end
      end
      if (accept && in_data.opcode == OP_READ) begin
        rd_p <= {in_data.byte_index, 1'b0};
      end

      // A nibble past the stored pixels reads as zero.
      if (state == ST_RD_B) begin
        nib_hi <= ({1'b0, rd_p} < pixel_count) ? mem_q[27:24] : 4'd0;
      end
      if (state == ST_RD_C) begin
        nib_lo <= ({1'b0, rd_p + 1'b1} < pixel_count) ? mem_q[27:24] : 4'd0;
      end

      // Sweep pointer and return tags.
      if (rd_issue) begin
        sweep_addr <= sweep_addr + 1'b1;
      end else if (!is_sweep) begin
        sweep_addr <= '0;
      end
      rd_clamp_q <= rd_issue && (state == ST_CLAMP);
      rd_acc_q   <= rd_issue && (state == ST_ACC);
      rd_asn_q   <= rd_issue && (state == ST_ASSIGN);
      rd_addr_q  <= sweep_addr[PIX_AW-1:0];

      // Drain lets the last words of a sweep land before the next phase.
      if (sweep_done) begin
        drain_cnt <= DRAIN_CYCLES;
        case (state)
          ST_CLAMP: drain_ret <= ST_CLEAR;
          ST_ACC:   drain_ret <= ST_DIV;
          default:  drain_ret <= ST_CHECK;
        endcase
      end else if (state == ST_DRAIN) begin
        drain_cnt <= drain_cnt - 1'b1;
      end

      if (state == ST_CLEAR) begin
        changed  <= 1'b0;
        div_cell <= '0;
        div_chan <= CHAN_RED;
        div_wait <= 1'b0;
      end else if (links[MAX_COLORS].valid &&
                   links[MAX_COLORS].best != links[MAX_COLORS].old_label) begin
        changed <= 1'b1;
      end

      // Means: one division per cluster and channel.
      if (state == ST_DIV) begin
        if (!div_wait) begin
          div_wait <= 1'b1;
        end else if (div_done) begin
          div_wait <= 1'b0;
          if (div_chan == CHAN_BLUE) begin
            div_chan <= CHAN_RED;
            div_cell <= div_cell + 1'b1;
          end else begin
            div_chan <= div_chan + 1'b1;
          end
        end
      end

      if (state == ST_CHECK) begin
        passes     <= passes + 8'd1;
        emit_idx   <= '0;
        frame_done <= 1'b1;
      end else if (state == ST_EMIT && out_free) begin
        emit_idx <= emit_idx + 1'b1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  `KMQ_ASSERT_NOW(a_chain_in_assign, clk, rst, links[MAX_COLORS].valid, (state == ST_ASSIGN || state == ST_DRAIN))
  `KMQ_ASSERT_NOW(a_div_in_div, clk, rst, div_done, (state == ST_DIV))
  `KMQ_ASSERT_NOW(a_emit_range, clk, rst, (state == ST_EMIT), ({1'b0, emit_idx} < nc))
  `KMQ_ASSERT_NEXT(a_count_bound, clk, rst, 1'b1, (pixel_count <= CNT_W'(MAX_PIXELS)))

endmodule

>>> bench/tb.sv
// Self-checking bench for the k-means color quantizer: loads frames, reads label bytes.
// Depends on kmq_pkg and the kmeans_color_quantizer RTL.
`timescale 1ns / 1ps
module tb;
  import kmq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  kmeans_color_quantizer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state. Frames are kept small, so a short pixel array suffices; pixel
  // indexes beyond it are never loaded, so they always read as zero past the count.
  localparam int FRAME_CAP = 64;
  logic [3:0]  pix_label [FRAME_CAP];
  logic [23:0] pix_rgb   [FRAME_CAP];
  int          pix_count;
  logic [23:0] centroid [MAX_COLORS];
  logic        frame_done;
  logic [7:0]  passes_done;
  logic [4:0]  num_colors;
  logic        channel_order;
  logic [7:0]  max_passes;

  out_word_t expected_words[$];
  int        mismatches;
  bit        hold_off;
  int        long_stall;

  function automatic int colors_in_use();
    if (num_colors < 1) return 1;
    if (num_colors > MAX_COLORS) return MAX_COLORS;
    return num_colors;
  endfunction

  // One full clustering run over the stored frame, as the block does it.
  task automatic cluster_frame();
    int nc, maxp, i, j, best, bestd, d, dr, dg, db;
    longint sr [MAX_COLORS];
    longint sg [MAX_COLORS];
    longint sb [MAX_COLORS];
    int     sz [MAX_COLORS];
    bit changed;
    nc = colors_in_use();
    maxp = (max_passes == 0) ? 1 : max_passes;
    for (i = 0; i < pix_count; i++)
      if (pix_label[i] >= nc) pix_label[i] = 4'(nc - 1);
    passes_done = 0;
    do begin
      changed = 0;
      for (j = 0; j < MAX_COLORS; j++) begin
        sr[j] = 0; sg[j] = 0; sb[j] = 0; sz[j] = 0;
      end
      for (i = 0; i < pix_count; i++) begin
        sr[pix_label[i]] += pix_rgb[i][23:16];
        sg[pix_label[i]] += pix_rgb[i][15:8];
        sb[pix_label[i]] += pix_rgb[i][7:0];
        sz[pix_label[i]]++;
      end
      for (j = 0; j < nc; j++) begin
        if (sz[j] != 0)
          centroid[j] = {8'(sr[j] / sz[j]), 8'(sg[j] / sz[j]), 8'(sb[j] / sz[j])};
        else
          centroid[j] = '0;
      end
      for (i = 0; i < pix_count; i++) begin
        best = 0; bestd = 0;
        for (j = 0; j < nc; j++) begin
          dr = int'(centroid[j][23:16]) - int'(pix_rgb[i][23:16]);
          dg = int'(centroid[j][15:8]) - int'(pix_rgb[i][15:8]);
          db = int'(centroid[j][7:0]) - int'(pix_rgb[i][7:0]);
          d = dr * dr + dg * dg + db * db;
          if (j == 0 || d < bestd) begin
            bestd = d; best = j;
          end
        end
        if (pix_label[i] != best) changed = 1;
        pix_label[i] = 4'(best);
      end
      passes_done++;
    end while (changed && passes_done < maxp);
  endtask

  function automatic logic [3:0] label_at(int idx);
    if (idx >= pix_count) return 4'd0;
    return pix_label[idx];
  endfunction

  // Works out the words that one accepted item should produce.
  task automatic predict_words(in_word_t w);
    out_word_t o;
    int nc;
    if (w.opcode == OP_READ) begin
      o = '0;
      o.kind = KIND_READ;
      o.packed_byte = {label_at(2 * w.byte_index), label_at(2 * w.byte_index + 1)};
      o.passes_used = passes_done;
      o.last = 1'b1;
      expected_words.push_back(o);
      return;
    end
    if (frame_done) begin
      pix_count = 0;
      frame_done = 0;
    end
    pix_label[pix_count] = w.initial_label;
    if (channel_order)
      pix_rgb[pix_count] = {w.pixel_word[15:8], w.pixel_word[23:16], w.pixel_word[31:24]};
    else
      pix_rgb[pix_count] = w.pixel_word[31:8];
    pix_count++;
    if (!w.last_pixel) return;
    cluster_frame();
    frame_done = 1;
    nc = colors_in_use();
    for (int j = 0; j < nc; j++) begin
      o = '0;
      o.kind = KIND_PALETTE;
      o.palette_index = 4'(j);
      o.red = centroid[j][23:16];
      o.green = centroid[j][15:8];
      o.blue = centroid[j][7:0];
      o.passes_used = passes_done;
      o.last = (j + 1 == nc);
      expected_words.push_back(o);
    end
  endtask

  // Sends one item with a random gap in front; the prediction is made on acceptance.
  // Valid stays up after acceptance until a gap or a pause takes it down.
  task automatic send_item(in_word_t w);
    int gap;
    gap = $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    predict_words(w);
  endtask

  // Stops sending, waits until every expected word has come, then lets the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (int'(DRAIN_CYCLES) + 20) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_NUM_COLORS:    num_colors = val[4:0];
      CFG_CHANNEL_ORDER: channel_order = val[0];
      CFG_MAX_PASSES:    max_passes = val;
      default: ;
    endcase
  endtask

  function automatic in_word_t load_word(logic [31:0] px, logic [3:0] lab, logic lastp);
    in_word_t w;
    w = '0;
    w.opcode = OP_LOAD;
    w.pixel_word = px;
    w.initial_label = lab;
    w.last_pixel = lastp;
    w.byte_index = 17'($urandom);
    return w;
  endfunction

  function automatic in_word_t read_word(logic [16:0] idx);
    in_word_t w;
    w = '0;
    w.opcode = OP_READ;
    w.byte_index = idx;
    w.pixel_word = $urandom;
    w.initial_label = 4'($urandom);
    w.last_pixel = 1'($urandom);
    return w;
  endfunction

  // Loads a frame of n pixels with random content, then reads back its label bytes.
  task automatic random_frame(int n);
    for (int i = 0; i < n; i++)
      send_item(load_word($urandom, 4'($urandom), i == n - 1));
    for (int i = 0; i < (n + 1) / 2 + 1; i++)
      send_item(read_word((i == (n + 1) / 2) ? 17'($urandom) : 17'(i)));
  endtask

  // Extremes of the fields, labels above the clusters in use, empty clusters and ties.
  task automatic test_directed();
    send_item(read_word(17'd0));         // a read before any run sees nothing loaded
    send_item(load_word(32'hFFFFFFFF, 4'hF, 1'b0));
    send_item(load_word(32'h00000000, 4'h0, 1'b0));
    send_item(read_word(17'd0));         // labels as loaded, no clamp yet
    send_item(load_word(32'h80808000, 4'h7, 1'b1));
    send_item(read_word(17'd0));
    send_item(read_word(17'd1));
    send_item(read_word(17'h1FFFF));     // far beyond the frame
    drain_results();
    write_register(CFG_NUM_COLORS, 8'd2);
    write_register(CFG_CHANNEL_ORDER, 8'd1);
    write_register(CFG_MAX_PASSES, 8'd1);
    // Two pixels split one cluster around its mean; labels above 1 clamp to 1.
    send_item(load_word(32'h000000FF, 4'hF, 1'b0));
    send_item(load_word(32'hFF0000AA, 4'h9, 1'b0));
    send_item(load_word(32'h7F7F7F00, 4'h0, 1'b1));
    send_item(read_word(17'd0));
    send_item(read_word(17'd1));
    drain_results();
    write_register(CFG_NUM_COLORS, 8'd0);    // acts as a single cluster
    write_register(CFG_MAX_PASSES, 8'd0);    // acts as one pass
    send_item(load_word(32'h12345678, 4'hA, 1'b1));
    send_item(read_word(17'd0));
    drain_results();
    write_register(CFG_NUM_COLORS, 8'd31);   // clamps to the maximum
    write_register(CFG_MAX_PASSES, 8'd255);
    write_register(CFG_CHANNEL_ORDER, 8'd0);
    send_item(load_word(32'hAAAAAAAA, 4'h5, 1'b0));
    send_item(load_word(32'h55555555, 4'hE, 1'b1));
    send_item(read_word(17'd0));
    drain_results();
  endtask

  task automatic test_random_frames();
    for (int f = 0; f < 10; f++) begin
      write_register(CFG_NUM_COLORS, 8'($urandom_range(0, 31)));
      write_register(CFG_CHANNEL_ORDER, 8'($urandom));
      write_register(CFG_MAX_PASSES, 8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 24)));
      random_frame($urandom_range(1, 9));
      drain_results();
    end
  endtask

  // The receiver holds off while the sender keeps offering reads so the block backs up.
  task automatic test_back_pressure();
    long_stall = 200;
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) send_item(read_word(17'($urandom_range(0, 5))));
    drain_results();
  endtask

  // Receiver: random stalls per word, and a long hold-off on request.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (long_stall) @(posedge clk);
        hold_off = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(0, 11);
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Checker: each accepted word against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data);
      end else begin
        if (out_data !== expected_words[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", expected_words[0], out_data);
        end
        void'(expected_words.pop_front());
      end
    end
  end

  initial begin
    mismatches = 0;
    hold_off = 1'b0;
    pix_count = 0;
    frame_done = 0;
    passes_done = 0;
    num_colors = NUM_COLORS_RESET;
    channel_order = 1'b0;
    max_passes = MAX_PASSES_RESET;
    for (int j = 0; j < MAX_COLORS; j++) centroid[j] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_frames();
    test_back_pressure();
    drain_results();
    if (mismatches == 0 && expected_words.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end
endmodule

>>> files.f
+incdir+src
src/kmq_pkg.sv
src/kmq_ram.sv
src/kmq_cell.sv
src/kmq_divider.sv
src/kmeans_color_quantizer.sv
bench/tb.sv
